### sv/ethip_pkg.sv
`timescale 1ns / 1ps
package ethip_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 16384;
  localparam int DEF_MAX_EXT_HEADERS = 8;

  // positions inside the parser; an ipv6 chain may run past the frame store
  localparam int PTR_W  = 17;
  localparam int CALC_W = 18;
  localparam int FLEN_W = 16;
  localparam int SEEN_W = 4;
  localparam int OFS_W  = 15;

  localparam int ETH_HEADER_BYTES  = 14;
  localparam int IPV4_MIN_LEN      = 20;
  localparam int IPV6_HDR_LEN      = 40;
  localparam int TCP_MIN_LEN       = 20;
  localparam int UDP_HEADER_BYTES  = 8;
  localparam int ICMP_HEADER_BYTES = 4;

  // fixed byte positions in the frame
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IHL      = 14;
  localparam int POS_TLEN_HI  = 16;
  localparam int POS_TLEN_LO  = 17;
  localparam int POS_FRAG_HI  = 20;
  localparam int POS_FRAG_LO  = 21;
  localparam int POS_V6_NEXT  = 20;
  localparam int POS_V4_PROTO = 23;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;

  typedef enum logic [1:0] {
    NET_OTHER = 2'd0,
    NET_IPV4  = 2'd1,
    NET_IPV6  = 2'd2
  } net_kind_t;

  // fields captured over one frame, handed over on the last byte
  typedef struct packed {
    logic [FLEN_W-1:0] flen;
    logic [15:0]       etype;
    logic [3:0]        ihl;
    logic [15:0]       ilen;
    logic              frag;
    logic [7:0]        proto4;
    logic [7:0]        next;
    logic [SEEN_W-1:0] seen;
    logic [PTR_W-1:0]  extp;
    logic [7:0]        t0;
    logic [15:0]       ulen;
    logic [3:0]        tcpoff;
  } snap_t;

  typedef struct packed {
    logic              eth_found;
    net_kind_t         network_kind;
    logic              network_found;
    logic [7:0]        transport_proto;
    logic              transport_found;
    logic [OFS_W-1:0]  transport_offset;
    logic              payload_found;
    logic [OFS_W-1:0]  payload_offset;
    logic [OFS_W-1:0]  frame_end;
    logic [SEEN_W-1:0] ext_header_count;
  } res_t;

  function automatic logic is_ext(input logic [7:0] n);
    return (n == PROTO_HOPOPT) || (n == PROTO_ROUTE) ||
           (n == PROTO_FRAG) || (n == PROTO_DSTOPT);
  endfunction

  function automatic logic icmp_known(input logic [7:0] t);
    logic k;
    case (t)
      8'd0, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
      8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd37, 8'd38: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] icmp_body(input logic [7:0] t);
    logic [4:0] b;
    case (t)
      8'd13, 8'd14:        b = 5'd16;
      8'd17, 8'd18, 8'd38: b = 5'd8;
      default:             b = 5'd4;
    endcase
    return b;
  endfunction

endpackage

### sv/ethip_if.sv
`timescale 1ns / 1ps
interface ethip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ethip_out_if;
  logic        valid;
  logic        ready;
  logic        eth_found;
  logic [1:0]  network_kind;
  logic        network_found;
  logic [7:0]  transport_proto;
  logic        transport_found;
  logic [14:0] transport_offset;
  logic        payload_found;
  logic [14:0] payload_offset;
  logic [14:0] frame_end;
  logic [3:0]  ext_header_count;
  modport source (output valid, output eth_found, output network_kind, output network_found,
                  output transport_proto, output transport_found, output transport_offset,
                  output payload_found, output payload_offset, output frame_end,
                  output ext_header_count, input ready);
  modport sink   (input valid, input eth_found, input network_kind, input network_found,
                  input transport_proto, input transport_found, input transport_offset,
                  input payload_found, input payload_offset, input frame_end,
                  input ext_header_count, output ready);
endinterface

### sv/ethip_capture.sv
`timescale 1ns / 1ps
module ethip_capture import ethip_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int MAX_EXT_HEADERS = DEF_MAX_EXT_HEADERS
) (
  input  logic       clk,
  input  logic       rst_n,
  ethip_in_if.sink   in_chan,
  output logic       snap_valid,
  input  logic       snap_ready,
  output snap_t      snap
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [3:0]        ihl_r, ihl_nxt;
  logic [15:0]       ilen_r, ilen_nxt;
  logic              frag_hi_r, frag_hi_nxt;
  logic              frag_lo_r, frag_lo_nxt;
  logic [7:0]        proto4_r, proto4_nxt;
  logic [7:0]        next_r, next_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [PTR_W-1:0]  extp_r, extp_nxt;
  logic              wait_r, wait_nxt;
  logic [7:0]        t0_r, t0_nxt;
  logic [15:0]       ulen_r, ulen_nxt;
  logic [3:0]        tcpoff_r, tcpoff_nxt;
  logic              snap_valid_r, snap_valid_nxt;
  snap_t             snap_r, snap_nxt;

  logic             accept;
  logic             store;
  logic [PTR_W-1:0] pos;
  logic             is_v6;
  logic [3:0]       ihl_cur;
  logic [PTR_W-1:0] tstart;
  logic             clr_t;
  logic [7:0]       b;

  assign b          = in_chan.frame_byte;
  assign in_chan.ready = !snap_valid_r || snap_ready;
  assign accept     = in_chan.valid && in_chan.ready;
  assign store      = count_r < CNT_W'(MAX_FRAME_BYTES);
  assign pos        = PTR_W'(count_r);
  assign is_v6      = (etype_r == ETYPE_IPV6) && (pos >= PTR_W'(ETH_HEADER_BYTES));
  assign ihl_cur    = (pos == PTR_W'(POS_IHL)) ? b[3:0] : ihl_r;
  assign tstart     = is_v6 ? extp_r : PTR_W'(ETH_HEADER_BYTES) + PTR_W'({ihl_cur, 2'b00});
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    count_nxt   = count_r;
    etype_nxt   = etype_r;
    ihl_nxt     = ihl_r;
    ilen_nxt    = ilen_r;
    frag_hi_nxt = frag_hi_r;
    frag_lo_nxt = frag_lo_r;
    proto4_nxt  = proto4_r;
    next_nxt    = next_r;
    seen_nxt    = seen_r;
    extp_nxt    = extp_r;
    wait_nxt    = wait_r;
    t0_nxt      = t0_r;
    ulen_nxt    = ulen_r;
    tcpoff_nxt  = tcpoff_r;
    clr_t       = 1'b0;
    if (accept) begin
      // frame start: unread bytes count as zero
      if (count_r == '0) begin
        etype_nxt   = '0;
        ihl_nxt     = '0;
        ilen_nxt    = '0;
        frag_hi_nxt = 1'b0;
        frag_lo_nxt = 1'b0;
        proto4_nxt  = '0;
        next_nxt    = '0;
        seen_nxt    = '0;
        extp_nxt    = PTR_W'(ETH_HEADER_BYTES + IPV6_HDR_LEN);
        wait_nxt    = 1'b0;
        t0_nxt      = '0;
        ulen_nxt    = '0;
        tcpoff_nxt  = '0;
      end
      if (store) begin
        if (pos == PTR_W'(POS_ETYPE_HI)) etype_nxt[15:8] = b;
        if (pos == PTR_W'(POS_ETYPE_LO)) etype_nxt[7:0]  = b;
        if (pos == PTR_W'(POS_IHL))      ihl_nxt         = b[3:0];
        if (pos == PTR_W'(POS_TLEN_HI))  ilen_nxt[15:8]  = b;
        if (pos == PTR_W'(POS_TLEN_LO))  ilen_nxt[7:0]   = b;
        if (pos == PTR_W'(POS_FRAG_HI))  frag_hi_nxt     = |b[5:0];
        if (pos == PTR_W'(POS_V6_NEXT))  next_nxt        = b;
        if (pos == PTR_W'(POS_FRAG_LO))  frag_lo_nxt     = |b;
        if (pos == PTR_W'(POS_V4_PROTO)) proto4_nxt      = b;
        // ipv6 extension chain: next header byte, then length byte
        if (is_v6) begin
          if (wait_r) begin
            extp_nxt   = extp_r + PTR_W'({(9'(b) + 9'd1), 3'b000});
            wait_nxt   = 1'b0;
            clr_t      = 1'b1;
            t0_nxt     = '0;
            ulen_nxt   = '0;
            tcpoff_nxt = '0;
          end else if (pos == extp_r && is_ext(next_r) &&
                       seen_r < SEEN_W'(MAX_EXT_HEADERS)) begin
            next_nxt = b;
            seen_nxt = seen_r + SEEN_W'(1);
            wait_nxt = 1'b1;
          end
        end
        if (!clr_t) begin
          if (pos == tstart)                 t0_nxt        = b;
          if (pos == tstart + PTR_W'(4))     ulen_nxt[15:8] = b;
          if (pos == tstart + PTR_W'(5))     ulen_nxt[7:0]  = b;
          if (pos == tstart + PTR_W'(12))    tcpoff_nxt    = b[7:4];
        end
      end
      if (in_chan.frame_last) count_nxt = '0;
      else if (store)         count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    snap_nxt        = snap_r;
    snap_valid_nxt  = snap_valid_r;
    if (snap_ready) snap_valid_nxt = 1'b0;
    if (accept && in_chan.frame_last) begin
      snap_valid_nxt  = 1'b1;
      snap_nxt.flen   = store ? FLEN_W'(count_r) + FLEN_W'(1) : FLEN_W'(count_r);
      snap_nxt.etype  = etype_nxt;
      snap_nxt.ihl    = ihl_nxt;
      snap_nxt.ilen   = ilen_nxt;
      snap_nxt.frag   = frag_hi_nxt || frag_lo_nxt;
      snap_nxt.proto4 = proto4_nxt;
      snap_nxt.next   = next_nxt;
      snap_nxt.seen   = seen_nxt;
      // frame ended on an extension header's first byte: length reads as zero
      snap_nxt.extp   = wait_nxt ? extp_nxt + PTR_W'(8) : extp_nxt;
      snap_nxt.t0     = t0_nxt;
      snap_nxt.ulen   = ulen_nxt;
      snap_nxt.tcpoff = tcpoff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      wait_r       <= 1'b0;
      snap_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      wait_r       <= wait_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    etype_r   <= etype_nxt;
    ihl_r     <= ihl_nxt;
    ilen_r    <= ilen_nxt;
    frag_hi_r <= frag_hi_nxt;
    frag_lo_r <= frag_lo_nxt;
    proto4_r  <= proto4_nxt;
    next_r    <= next_nxt;
    seen_r    <= seen_nxt;
    extp_r    <= extp_nxt;
    t0_r      <= t0_nxt;
    ulen_r    <= ulen_nxt;
    tcpoff_r  <= tcpoff_nxt;
    snap_r    <= snap_nxt;
  end

endmodule

### sv/ethip_eval.sv
`timescale 1ns / 1ps
module ethip_eval import ethip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       snap_valid,
  output logic       snap_ready,
  input  snap_t      snap,
  ethip_out_if.source out_chan
);

  res_t res, res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [CALC_W-1:0] flen, hl, ilen0, p, endv, thl, pp;
  logic [7:0]        nxt;
  logic              go, tok, pok;

  assign snap_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    res      = '0;
    flen     = CALC_W'(snap.flen);
    hl       = CALC_W'({snap.ihl, 2'b00});
    ilen0    = (snap.ilen == '0) ? flen - CALC_W'(ETH_HEADER_BYTES) : CALC_W'(snap.ilen);
    p        = '0;
    endv     = flen;
    nxt      = '0;
    go       = 1'b0;
    tok      = 1'b0;
    pok      = 1'b0;
    thl      = '0;
    pp       = '0;
    res.frame_end = flen[OFS_W-1:0];
    if (flen >= CALC_W'(ETH_HEADER_BYTES)) begin
      res.eth_found = 1'b1;
      if (snap.etype == ETYPE_IPV4) begin
        res.network_kind = NET_IPV4;
        if (flen >= CALC_W'(ETH_HEADER_BYTES + IPV4_MIN_LEN) &&
            CALC_W'(ETH_HEADER_BYTES) + hl <= flen) begin
          res.network_found = 1'b1;
          if (CALC_W'(ETH_HEADER_BYTES) + ilen0 <= flen && !snap.frag) begin
            endv          = CALC_W'(ETH_HEADER_BYTES) + ilen0;
            res.frame_end = endv[OFS_W-1:0];
            p             = CALC_W'(ETH_HEADER_BYTES) + hl;
            nxt           = snap.proto4;
            go            = 1'b1;
          end
        end
      end else if (snap.etype == ETYPE_IPV6) begin
        res.network_kind = NET_IPV6;
        if (flen >= CALC_W'(ETH_HEADER_BYTES + IPV6_HDR_LEN)) begin
          res.network_found    = 1'b1;
          res.ext_header_count = snap.seen;
          if (!is_ext(snap.next)) begin
            p   = CALC_W'(snap.extp);
            nxt = snap.next;
            go  = 1'b1;
          end
        end
      end
    end
    if (go) begin
      res.transport_proto = nxt;
      case (nxt)
        PROTO_ICMP, PROTO_ICMPV6: begin
          thl = CALC_W'(ICMP_HEADER_BYTES);
          tok = 1'b1;
        end
        PROTO_TCP: begin
          thl = CALC_W'({snap.tcpoff, 2'b00});
          tok = p + CALC_W'(TCP_MIN_LEN) <= endv;
        end
        PROTO_UDP: begin
          thl = CALC_W'(UDP_HEADER_BYTES);
          tok = 1'b1;
        end
        default: begin
          thl = '0;
          tok = 1'b0;
        end
      endcase
      pp = p + thl;
      if (tok && pp <= endv) begin
        res.transport_found  = 1'b1;
        res.transport_offset = p[OFS_W-1:0];
        case (nxt)
          PROTO_ICMP:   pok = icmp_known(snap.t0) &&
                              (pp + CALC_W'(icmp_body(snap.t0)) <= endv);
          PROTO_ICMPV6: pok = 1'b1;
          PROTO_TCP:    pok = pp < endv;
          PROTO_UDP:    pok = p + CALC_W'(snap.ulen) <= endv;
          default:      pok = 1'b0;
        endcase
        if (pok) begin
          res.payload_found  = 1'b1;
          res.payload_offset = pp[OFS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (snap_valid && snap_ready) begin
      res_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.eth_found        = res_r.eth_found;
  assign out_chan.network_kind     = res_r.network_kind;
  assign out_chan.network_found    = res_r.network_found;
  assign out_chan.transport_proto  = res_r.transport_proto;
  assign out_chan.transport_found  = res_r.transport_found;
  assign out_chan.transport_offset = res_r.transport_offset;
  assign out_chan.payload_found    = res_r.payload_found;
  assign out_chan.payload_offset   = res_r.payload_offset;
  assign out_chan.frame_end        = res_r.frame_end;
  assign out_chan.ext_header_count = res_r.ext_header_count;

endmodule

### sv/ethernet_ip_header_parser_top.sv
`timescale 1ns / 1ps
// throughput: one frame byte per cycle, frames of any length back to back while result words
// are taken; a held result word fills the snapshot register, which then drops input ready.
// Fields pass the snapshot register, then the result register. Rate is set by the per-byte
// field capture, a combinational compare of byte position with fixed and tracked header offsets
// reset: synchronous active low; clears the byte count, handshake flags and the chain length-wait flag
module ethernet_ip_header_parser_top import ethip_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int MAX_EXT_HEADERS = DEF_MAX_EXT_HEADERS
) (
  input  logic        clk,
  input  logic        rst_n,
  ethip_in_if.sink    in_chan,
  ethip_out_if.source out_chan
);

  // captured header fields of a finished frame, one word deep
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  // byte stage: counts positions, grabs ethertype, ip and transport fields,
  // follows the ipv6 extension chain as it streams past
  ethip_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // frame stage: length checks, trimming and offsets into the result register
  ethip_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_chan   (out_chan)
  );

endmodule

### verif/tb_ethernet_ip_header_parser_top.sv
`timescale 1ns / 1ps
module tb_ethernet_ip_header_parser_top;
  import ethip_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 8;

  typedef logic [7:0] frame_q_t[$];

  // frame parser scoreboard: collects frame bytes, predicts one result word per frame
  class frame_scoreboard;
    logic [7:0] frame_bytes[$];
    int         frame_len;
    res_t       pending_q[$];
    int         mismatches;

    function new();
      frame_len  = 0;
      mismatches = 0;
    endfunction

    function int peek(int pos);
      if (pos < frame_len && pos < DEF_MAX_FRAME_BYTES) return frame_bytes[pos];
      return 0;
    endfunction

    function bit ext_hdr(int n);
      return n == PROTO_HOPOPT || n == PROTO_ROUTE || n == PROTO_FRAG || n == PROTO_DSTOPT;
    endfunction

    // standard icmp body size per type; -1 for types with no known layout
    function int icmp_msg_len(int ty);
      case (ty)
        0, 3, 4, 5, 8, 9, 10, 11, 12, 15, 16, 37: return 4;
        13, 14:     return 16;
        17, 18, 38: return 8;
        default:    return -1;
      endcase
    endfunction

    function res_t parse_frame();
      res_t r;
      int   fend, p, nxt, hl, seen, et, ilen, frag, t, body;
      bit   ok;
      r = '0;
      fend = frame_len;
      nxt = 0;
      seen = 0;
      r.frame_end = fend[14:0];
      if (frame_len < ETH_HEADER_BYTES) return r;
      r.eth_found = 1'b1;
      et = (peek(POS_ETYPE_HI) << 8) | peek(POS_ETYPE_LO);
      p = ETH_HEADER_BYTES;
      if (et == ETYPE_IPV4) begin
        r.network_kind = NET_IPV4;
        if (p + IPV4_MIN_LEN > fend) return r;
        hl = (peek(POS_IHL) & 15) << 2;
        if (p + hl > fend) return r;
        r.network_found = 1'b1;
        ilen = (peek(POS_TLEN_HI) << 8) | peek(POS_TLEN_LO);
        if (ilen == 0) ilen = frame_len - ETH_HEADER_BYTES;
        if (p + ilen > fend) return r;
        frag = (peek(POS_FRAG_HI) << 8) | peek(POS_FRAG_LO);
        // any fragment offset or more-fragments flag stops here
        if ((frag & 16'h3FFF) != 0) return r;
        fend = p + ilen;
        r.frame_end = fend[14:0];
        p += hl;
        nxt = peek(POS_V4_PROTO);
      end else if (et == ETYPE_IPV6) begin
        r.network_kind = NET_IPV6;
        if (p + IPV6_HDR_LEN > fend) return r;
        r.network_found = 1'b1;
        nxt = peek(POS_V6_NEXT);
        p += IPV6_HDR_LEN;
        while (ext_hdr(nxt)) begin
          if (p >= fend || seen >= DEF_MAX_EXT_HEADERS) begin
            r.ext_header_count = seen[3:0];
            return r;
          end
          nxt = peek(p);
          p += (peek(p + 1) + 1) << 3;
          seen++;
        end
        r.ext_header_count = seen[3:0];
      end else begin
        return r;
      end

      r.transport_proto = nxt[7:0];
      if (nxt == PROTO_ICMP || nxt == PROTO_ICMPV6) hl = ICMP_HEADER_BYTES;
      else if (nxt == PROTO_TCP) begin
        if (p + TCP_MIN_LEN > fend) return r;
        hl = (peek(p + 12) >> 4) << 2;
      end else if (nxt == PROTO_UDP) hl = UDP_HEADER_BYTES;
      else return r;
      if (p + hl > fend) return r;
      r.transport_found  = 1'b1;
      r.transport_offset = p[14:0];
      t = p;
      p += hl;
      if (nxt == PROTO_ICMP) begin
        body = icmp_msg_len(peek(t));
        ok = body >= 0 && p + body <= fend;
      end else if (nxt == PROTO_ICMPV6) ok = 1'b1;
      else if (nxt == PROTO_TCP) ok = p < fend;
      else ok = t + ((peek(t + 4) << 8) | peek(t + 5)) <= fend;
      if (ok) begin
        r.payload_found  = 1'b1;
        r.payload_offset = p[14:0];
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (frame_len < DEF_MAX_FRAME_BYTES) begin
        frame_bytes.push_back(b);
        frame_len++;
      end
      if (last) begin
        pending_q.push_back(parse_frame());
        frame_bytes.delete();
        frame_len = 0;
      end
    endfunction

    task report(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report(name, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        report("result word with nothing pending", 1, 0);
        return;
      end
      want = pending_q.pop_front();
      check_field("eth_found",        got.eth_found,        want.eth_found);
      check_field("network_kind",     got.network_kind,     want.network_kind);
      check_field("network_found",    got.network_found,    want.network_found);
      check_field("transport_proto",  got.transport_proto,  want.transport_proto);
      check_field("transport_found",  got.transport_found,  want.transport_found);
      check_field("transport_offset", got.transport_offset, want.transport_offset);
      check_field("payload_found",    got.payload_found,    want.payload_found);
      check_field("payload_offset",   got.payload_offset,   want.payload_offset);
      check_field("frame_end",        got.frame_end,        want.frame_end);
      check_field("ext_header_count", got.ext_header_count, want.ext_header_count);
    endtask
  endclass

  logic clk;
  logic rst_n;

  ethip_in_if  in_ch();
  ethip_out_if out_ch();

  ethernet_ip_header_parser_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  frame_scoreboard sb;
  int send_idle_pct;   // chance the sender skips a cycle
  int recv_idle_pct;   // chance the receiver drops ready
  int recv_hold;       // long back-pressure stretch, counted down by the receiver
  int quiet_cycles;    // cycles with no word moving on either side

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver: ready changes on the falling edge only
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: note accepted bytes, check result words, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      res_t got;
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.frame_byte, in_ch.frame_last);
      if (out_ch.valid && out_ch.ready) begin
        got.eth_found        = out_ch.eth_found;
        got.network_kind     = net_kind_t'(out_ch.network_kind);
        got.network_found    = out_ch.network_found;
        got.transport_proto  = out_ch.transport_proto;
        got.transport_found  = out_ch.transport_found;
        got.transport_offset = out_ch.transport_offset;
        got.payload_found    = out_ch.payload_found;
        got.payload_offset   = out_ch.payload_offset;
        got.frame_end        = out_ch.frame_end;
        got.ext_header_count = out_ch.ext_header_count;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // append n bytes of value v, most significant first
  function automatic void put_val(ref logic [7:0] f[$], input int v, input int n);
    for (int i = n - 1; i >= 0; i--) f.push_back(8'(v >> (8 * i)));
  endfunction

  function automatic void put_rand(ref logic [7:0] f[$], input int n);
    for (int i = 0; i < n; i++) f.push_back(8'($urandom));
  endfunction

  // kind: 0 ipv4, 1 ipv6, 2 other ethertype, 3 short noise, -1 random
  // proto: 0 tcp, 1 udp, 2 icmp, 3 icmpv6, 4 random number, -1 random
  function automatic frame_q_t make_frame(int kind, int proto, bit clean);
    logic [7:0] f[$];
    logic [7:0] tq[$];
    int pnum, nbody, ihl, hdr_bytes, tlen, doff, nexts, elen, cut;
    int ext_codes[4] = '{PROTO_HOPOPT, PROTO_ROUTE, PROTO_FRAG, PROTO_DSTOPT};
    int icmp_types[17] = '{0, 3, 4, 5, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 37, 38};
    if (kind < 0) kind = ($urandom_range(9) < 8) ? $urandom_range(1) : $urandom_range(2, 3);
    if (proto < 0) proto = $urandom_range(4);
    if (kind == 3) begin
      put_rand(f, $urandom_range(1, 24));
      return f;
    end
    put_rand(f, 12);
    if (kind == 0) put_val(f, ETYPE_IPV4, 2);
    else if (kind == 1) put_val(f, ETYPE_IPV6, 2);
    else put_rand(f, 2);

    // transport header and body
    nbody = $urandom_range(0, 8);
    case (proto)
      0: begin
        doff = (clean || $urandom_range(7) != 0) ? $urandom_range(5, 7) : $urandom_range(15);
        put_rand(tq, 12);
        tq.push_back({4'(doff), 4'($urandom)});
        put_rand(tq, 7);
        if (doff > 5) put_rand(tq, (doff - 5) * 4);
        pnum = PROTO_TCP;
      end
      1: begin
        put_rand(tq, 4);
        put_val(tq, (clean || $urandom_range(5) != 0) ? 8 + nbody : $urandom, 2);
        put_rand(tq, 2);
        pnum = PROTO_UDP;
      end
      2: begin
        tq.push_back((clean || $urandom_range(4) != 0) ? 8'(icmp_types[$urandom_range(16)])
                                                       : 8'($urandom));
        put_rand(tq, 3);
        pnum = PROTO_ICMP;
      end
      3: begin
        put_rand(tq, 4);
        pnum = PROTO_ICMPV6;
      end
      default: begin
        put_rand(tq, 4);
        pnum = $urandom_range(255);
      end
    endcase
    put_rand(tq, nbody);

    if (kind == 0) begin
      ihl = (clean || $urandom_range(7) != 0) ? (($urandom_range(3) == 0) ? $urandom_range(6, 8) : 5)
                                              : $urandom_range(15);
      hdr_bytes = (ihl > 5) ? ihl * 4 : 20;
      tlen = hdr_bytes + tq.size();
      if (!clean && $urandom_range(7) == 0) tlen = 0;
      else if (!clean && $urandom_range(7) == 0) tlen = $urandom_range(65535);
      f.push_back({4'h4, 4'(ihl)});
      put_rand(f, 1);
      put_val(f, tlen, 2);
      put_rand(f, 2);
      if (clean || $urandom_range(5) != 0) put_val(f, $urandom_range(1) << 14, 2);
      else put_rand(f, 2);
      put_rand(f, 1);
      f.push_back(8'(pnum));
      put_rand(f, 10);
      if (hdr_bytes > 20) put_rand(f, hdr_bytes - 20);
    end else begin
      nexts = ($urandom_range(2) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 10);
      put_rand(f, 6);
      f.push_back((nexts > 0) ? 8'(ext_codes[$urandom_range(3)]) : 8'(pnum));
      put_rand(f, 33);
      for (int e = 0; e < nexts; e++) begin
        elen = $urandom_range(0, 2);
        f.push_back((e < nexts - 1) ? 8'(ext_codes[$urandom_range(3)]) : 8'(pnum));
        f.push_back(8'(elen));
        put_rand(f, (elen + 1) * 8 - 2);
      end
    end
    foreach (tq[i]) f.push_back(tq[i]);
    if (!clean) begin
      if ($urandom_range(3) == 0) put_rand(f, $urandom_range(1, 6));
      if ($urandom_range(4) == 0) begin
        cut = $urandom_range(1, f.size());
        while (f.size() > cut) void'(f.pop_back());
      end
    end
    return f;
  endfunction

  // offer one frame, one word per accepted handshake
  task automatic send_frame(input frame_q_t f);
    foreach (f[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      @(negedge clk);
      in_ch.valid      <= 1'b1;
      in_ch.frame_byte <= f[i];
      in_ch.frame_last <= (i == f.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
    end
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // sender waits until every result word has come back
  task automatic drain_results();
    idle_sender();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_frames(int n);
    for (int k = 0; k < n; k++) send_frame(make_frame(-1, -1, $urandom_range(1)));
  endtask

  initial begin
    frame_q_t f;
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 0;
    quiet_cycles  = 0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = 8'h00;
    in_ch.frame_last = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: tiny frames, bare ethernet header, all-ones header
    send_frame('{8'hFF});
    f = {};
    put_rand(f, 13);
    send_frame(f);
    f = {};
    put_val(f, 0, 14);
    send_frame(f);
    f = {};
    put_val(f, -1, 4);
    put_val(f, -1, 4);
    put_val(f, -1, 4);
    put_val(f, -1, 4);
    send_frame(f);
    // ipv4 and ipv6 with every transport, then one other ethertype, well formed
    for (int k = 0; k < 2; k++)
      for (int pr = 0; pr < 5; pr++) send_frame(make_frame(k, pr, 1'b1));
    send_frame(make_frame(2, 0, 1'b1));
    drain_results();

    // random: slow receiver
    send_idle_pct = 23;
    recv_idle_pct = 84;
    random_frames(2);
    drain_results();

    // random: slow sender
    send_idle_pct = 84;
    recv_idle_pct = 23;
    random_frames(2);
    drain_results();

    // random: full rate, with a long receiver hold while short frames keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(1);
    recv_hold = 600;
    for (int k = 0; k < 6; k++) send_frame(make_frame(3, -1, 1'b0));
    random_frames(1);

    idle_sender();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
